// ----- rtl/rtos_pkg.sv -----
// ----------------------------------------------------------------------------
// rtos_pkg
// Shared types and codes for the scheduler kernel core.
// ----------------------------------------------------------------------------
package rtos_pkg;

   localparam logic [2:0] REQ_CREATE   = 3'd0;
   localparam logic [2:0] REQ_TICK     = 3'd1;
   localparam logic [2:0] REQ_DISPATCH = 3'd2;
   localparam logic [2:0] REQ_YIELD    = 3'd3;
   localparam logic [2:0] REQ_SLEEP    = 3'd4;
   localparam logic [2:0] REQ_WAIT     = 3'd5;
   localparam logic [2:0] REQ_POST     = 3'd6;
   localparam logic [2:0] REQ_SEM      = 3'd7;

   localparam logic [2:0] ST_INVALID = 3'd0;
   localparam logic [2:0] ST_UNRUN   = 3'd1;
   localparam logic [2:0] ST_READY   = 3'd2;
   localparam logic [2:0] ST_DELAYED = 3'd3;
   localparam logic [2:0] ST_BLOCKED = 3'd4;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_FULL     = 3'd1;
   localparam logic [2:0] ERR_DUP      = 3'd2;
   localparam logic [2:0] ERR_BAD_SEM  = 3'd3;
   localparam logic [2:0] ERR_Q_FULL   = 3'd4;
   localparam logic [2:0] ERR_NO_READY = 3'd5;

   localparam logic [1:0] CSR_PRIORITY = 2'd0;
   localparam logic [1:0] CSR_PREEMPT  = 2'd1;
   localparam logic [1:0] CSR_INHERIT  = 2'd2;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] task_key;
      logic [3:0]  task_priority;
      logic [31:0] sleep_ticks;
      logic [2:0]  sem_index;
      logic [15:0] initial_count;
   } req_type_type;

   typedef struct packed {
      logic       done_ok;
      logic [3:0] task_index;
      logic [2:0] new_sem;
      logic       first_run;
      logic       switch_request;
      logic       released;
      logic [2:0] error_code;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic start;      // latch request, start walk
      logic scan;       // one slot of the pre pass or walk
      logic finish;     // commit request result
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic scan_last;  // current scan step is the last one
   } sts_type;

endpackage

// ----- rtl/rtos_stream_if.sv -----
// ----------------------------------------------------------------------------
// rtos_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface rtos_stream_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/rtos_task_scheduler_kernel_core.sv -----
// ----------------------------------------------------------------------------
// rtos_task_scheduler_kernel_core
// Hardware kernel: task table, weighted round-robin dispatch, semaphores.
// ----------------------------------------------------------------------------
// channel | dir | handshake   | payload
// req     | in  | valid/ready | request type, key, priority, ticks, sem, count
// rsp     | out | valid/ready | ok, task index, sem, flags, error
// csr     | in  | write only  | mode bits
// A dispatch with a runnable task adds a weighted walk of up to 17*NUM_TASKS
// slot visits after the sweep.
// Each request first sweeps the task table one slot per cycle.
// A new request is taken once the previous response has left.
// Synchronous active-high reset; wait queue storage is not reset.
module rtos_task_scheduler_kernel_core #(
   parameter int NUM_TASKS   = 16,
   parameter int NUM_SEMS    = 8,
   parameter int QUEUE_DEPTH = 8
) (
   input  logic  clock,
   input  logic  reset,
   rtos_stream_if.sink   req,
   rtos_stream_if.source rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic        csr_write_data
);
   rtos_pkg::cmd_type cmd;
   rtos_pkg::sts_type sts;
   logic prio_ff, preempt_ff, inherit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_ff <= 1'b1; preempt_ff <= 1'b1; inherit_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rtos_pkg::CSR_PRIORITY: prio_ff    <= csr_write_data;
            rtos_pkg::CSR_PREEMPT:  preempt_ff <= csr_write_data;
            rtos_pkg::CSR_INHERIT:  inherit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   rtos_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .sts
   );

   rtos_datapath #(.NUM_TASKS(NUM_TASKS), .NUM_SEMS(NUM_SEMS), .QUEUE_DEPTH(QUEUE_DEPTH))
   u_dp (
      .clock, .reset, .cmd, .sts, .req(req.payload),
      .priority_mode(prio_ff), .preempt_mode(preempt_ff), .inherit_mode(inherit_ff),
      .rsp(rsp.payload)
   );
endmodule

// ----- rtl/rtos_ctrl.sv -----
// ----------------------------------------------------------------------------
// rtos_ctrl
// Request sequencer: accept, walk the task slots, commit, hand off result.
// ----------------------------------------------------------------------------
module rtos_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rtos_pkg::cmd_type   cmd,
   input  rtos_pkg::sts_type   sts
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ----- rtl/rtos_datapath.sv -----
// ----------------------------------------------------------------------------
// rtos_datapath
// Task table, semaphores, wait queues and the slot walker.
// ----------------------------------------------------------------------------
module rtos_datapath #(
   parameter int NUM_TASKS   = 16,
   parameter int NUM_SEMS    = 8,
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rtos_pkg::cmd_type        cmd,
   output rtos_pkg::sts_type        sts,
   input  rtos_pkg::req_type_type   req,
   input  logic                     priority_mode,
   input  logic                     preempt_mode,
   input  logic                     inherit_mode,
   output rtos_pkg::rsp_type        rsp
);
   localparam int TW = $clog2(NUM_TASKS);
   localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(NUM_TASKS + 1);
   localparam int SCW = $clog2(NUM_SEMS + 1);
   localparam int LW = $clog2(QUEUE_DEPTH + 1);
   localparam int WALK = 17 * NUM_TASKS;
   localparam int WW = $clog2(WALK + 1);

   // task table
   logic [2:0]  tstate_ff [NUM_TASKS];
   logic [31:0] tkey_ff   [NUM_TASKS];
   logic [3:0]  bprio_ff  [NUM_TASKS];
   logic [3:0]  aprio_ff  [NUM_TASKS];
   logic [3:0]  skip_ff   [NUM_TASKS];
   logic [31:0] ticks_ff  [NUM_TASKS];
   logic        hvalid_ff [NUM_TASKS];
   logic [SW-1:0] hsem_ff [NUM_TASKS];
   logic [TW-1:0] ptr_ff, run_ff;
   logic [CW-1:0] tasks_ff;
   logic [15:0] count_ff [NUM_SEMS];
   logic [LW-1:0] qlen_ff [NUM_SEMS];
   logic [SCW-1:0] sems_ff;
   // wait queues as a circular buffer per semaphore; no reset
   logic [TW-1:0] queue_mem [NUM_SEMS*QUEUE_DEPTH];
   logic [QW-1:0] qhead_ff [NUM_SEMS];

   rtos_pkg::req_type_type r_ff;
   rtos_pkg::rsp_type rsp_ff;
   logic [TW-1:0] idx_ff;      // slot walk position
   logic [WW-1:0] step_ff;
   logic          any_ff, dup_ff, hit_ff, free_ff;
   logic [TW-1:0] free_idx_ff, pick_ff;
   logic [TW-1:0] cur_w;
   logic [SW-1:0] sem_w;
   logic          sem_ok;
   logic [3:0]    prio_w;

   assign rsp = rsp_ff;
   assign cur_w = run_ff;
   assign sem_w = SW'(r_ff.sem_index);
   assign sem_ok = ({1'b0, r_ff.sem_index} < 4'(sems_ff)) && (32'(r_ff.sem_index) < NUM_SEMS);
   assign prio_w = r_ff.task_priority ^ 4'h8;

   function automatic logic runnable(input logic [2:0] s);
      return (s == rtos_pkg::ST_READY) || (s == rtos_pkg::ST_UNRUN);
   endfunction

   logic [TW-1:0] nxt;
   assign nxt = (32'(idx_ff) == NUM_TASKS - 1) ? '0 : idx_ff + 1'b1;

   // scan is a pre pass over all slots (any / dup / free / tick) for every
   // request, then the weighted walk for a dispatch with a runnable task
   logic walk_phase_ff;
   logic pass_last, walk_last;
   assign pass_last = (32'(idx_ff) == NUM_TASKS - 1) && !walk_phase_ff;
   always_comb begin
      walk_last = 1'b0;
      if (walk_phase_ff) begin
         walk_last = (32'(step_ff) >= WALK - 1) ||
                     (runnable(tstate_ff[nxt]) &&
                      (!priority_mode || skip_ff[nxt] >= aprio_ff[nxt]));
      end
   end
   assign sts.scan_last = walk_phase_ff ? walk_last :
                          (pass_last && !(r_ff.req_type == rtos_pkg::REQ_DISPATCH &&
                                          (any_ff || runnable(tstate_ff[idx_ff]))));

   logic [$clog2(NUM_SEMS*QUEUE_DEPTH)-1:0] qaddr_w, qtail_w;
   logic [QW-1:0] tail_off;
   logic [QW:0]   tail_sum;
   always_comb begin
      tail_sum = (QW+1)'(qhead_ff[sem_w]) + (QW+1)'(qlen_ff[sem_w]);
      tail_off = QW'((32'(tail_sum) >= QUEUE_DEPTH) ? 32'(tail_sum) - QUEUE_DEPTH :
                                                      32'(tail_sum));
      qaddr_w  = $bits(qaddr_w)'(32'(sem_w) * QUEUE_DEPTH + 32'(qhead_ff[sem_w]));
      qtail_w  = $bits(qaddr_w)'(32'(sem_w) * QUEUE_DEPTH + 32'(tail_off));
   end
   logic [TW-1:0] qhead_data;
   always_ff @(posedge clock) begin
      qhead_data <= queue_mem[qaddr_w];
      if (cmd.finish && r_ff.req_type == rtos_pkg::REQ_WAIT &&
          tstate_ff[cur_w] != rtos_pkg::ST_INVALID && sem_ok && count_ff[sem_w] == 0 &&
          32'(qlen_ff[sem_w]) < QUEUE_DEPTH)
         queue_mem[qtail_w] <= cur_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            tstate_ff[i] <= rtos_pkg::ST_INVALID;
            tkey_ff[i] <= '0; bprio_ff[i] <= '0; aprio_ff[i] <= '0;
            skip_ff[i] <= '0; ticks_ff[i] <= '0; hvalid_ff[i] <= 1'b0;
            hsem_ff[i] <= '0;
         end
         for (int s = 0; s < NUM_SEMS; s++) begin
            count_ff[s] <= '0; qlen_ff[s] <= '0; qhead_ff[s] <= '0;
         end
         ptr_ff <= TW'(NUM_TASKS - 1);
         run_ff <= '0; tasks_ff <= '0; sems_ff <= '0;
         walk_phase_ff <= 1'b0;
         idx_ff <= '0; step_ff <= '0;
         any_ff <= 1'b0; dup_ff <= 1'b0; free_ff <= 1'b0; hit_ff <= 1'b0;
         free_idx_ff <= '0; pick_ff <= '0;
      end else begin
         if (cmd.start) begin
            r_ff <= req;
            idx_ff <= '0; step_ff <= '0; walk_phase_ff <= 1'b0;
            any_ff <= 1'b0; dup_ff <= 1'b0; free_ff <= 1'b0; hit_ff <= 1'b0;
         end
         if (cmd.scan && !walk_phase_ff) begin
            if (runnable(tstate_ff[idx_ff])) any_ff <= 1'b1;
            if (tstate_ff[idx_ff] != rtos_pkg::ST_INVALID && tkey_ff[idx_ff] == r_ff.task_key)
               dup_ff <= 1'b1;
            if (tstate_ff[idx_ff] == rtos_pkg::ST_INVALID && !free_ff) begin
               free_ff <= 1'b1; free_idx_ff <= idx_ff;
            end
            if (r_ff.req_type == rtos_pkg::REQ_TICK &&
                tstate_ff[idx_ff] == rtos_pkg::ST_DELAYED) begin
               if (ticks_ff[idx_ff] != 0) ticks_ff[idx_ff] <= ticks_ff[idx_ff] - 1'b1;
               else tstate_ff[idx_ff] <= rtos_pkg::ST_READY;
            end
            // inheritance pass: only commits when the wait really blocks
            if (r_ff.req_type == rtos_pkg::REQ_WAIT && inherit_mode &&
                tstate_ff[cur_w] != rtos_pkg::ST_INVALID && sem_ok &&
                count_ff[sem_w] == 0 && 32'(qlen_ff[sem_w]) < QUEUE_DEPTH &&
                ((hvalid_ff[idx_ff] && hsem_ff[idx_ff] == sem_w) || idx_ff == cur_w) &&
                aprio_ff[idx_ff] > aprio_ff[cur_w])
               aprio_ff[idx_ff] <= aprio_ff[cur_w];
            if (pass_last) begin
               if (r_ff.req_type == rtos_pkg::REQ_DISPATCH &&
                   (any_ff || runnable(tstate_ff[idx_ff]))) begin
                  walk_phase_ff <= 1'b1;
                  idx_ff <= ptr_ff;
               end else idx_ff <= nxt;
            end else idx_ff <= nxt;
         end
         if (cmd.scan && walk_phase_ff) begin
            step_ff <= step_ff + 1'b1;
            idx_ff  <= nxt;
            pick_ff <= nxt;
            if (priority_mode) begin
               if (runnable(tstate_ff[nxt])) begin
                  if (skip_ff[nxt] < aprio_ff[nxt]) skip_ff[nxt] <= skip_ff[nxt] + 1'b1;
                  else skip_ff[nxt] <= '0;
               end
            end else skip_ff[nxt] <= '0;
            hit_ff <= 1'b1;
         end
         if (cmd.finish) begin
            rsp_ff <= '0;
            unique case (r_ff.req_type)
               rtos_pkg::REQ_CREATE: begin
                  if (32'(tasks_ff) >= NUM_TASKS || !free_ff) rsp_ff.error_code <= rtos_pkg::ERR_FULL;
                  else if (dup_ff) rsp_ff.error_code <= rtos_pkg::ERR_DUP;
                  else begin
                     tstate_ff[free_idx_ff] <= rtos_pkg::ST_UNRUN;
                     tkey_ff[free_idx_ff] <= r_ff.task_key;
                     bprio_ff[free_idx_ff] <= prio_w;
                     aprio_ff[free_idx_ff] <= prio_w;
                     skip_ff[free_idx_ff] <= '0;
                     ticks_ff[free_idx_ff] <= '0;
                     hvalid_ff[free_idx_ff] <= 1'b0;
                     hsem_ff[free_idx_ff] <= '0;
                     tasks_ff <= tasks_ff + 1'b1;
                     rsp_ff.done_ok <= 1'b1;
                     rsp_ff.task_index <= 4'(free_idx_ff);
                  end
               end
               rtos_pkg::REQ_TICK: begin
                  rsp_ff.switch_request <= preempt_mode;
                  rsp_ff.done_ok <= 1'b1;
               end
               rtos_pkg::REQ_DISPATCH: begin
                  if (!hit_ff) rsp_ff.error_code <= rtos_pkg::ERR_NO_READY;
                  else begin
                     ptr_ff <= pick_ff; run_ff <= pick_ff;
                     rsp_ff.first_run <= (tstate_ff[pick_ff] == rtos_pkg::ST_UNRUN);
                     tstate_ff[pick_ff] <= rtos_pkg::ST_READY;
                     rsp_ff.done_ok <= 1'b1;
                     rsp_ff.task_index <= 4'(pick_ff);
                  end
               end
               rtos_pkg::REQ_YIELD: begin
                  if (tstate_ff[cur_w] != rtos_pkg::ST_INVALID) begin
                     tstate_ff[cur_w] <= rtos_pkg::ST_READY;
                     rsp_ff.done_ok <= 1'b1; rsp_ff.switch_request <= 1'b1;
                  end
               end
               rtos_pkg::REQ_SLEEP: begin
                  if (tstate_ff[cur_w] != rtos_pkg::ST_INVALID) begin
                     ticks_ff[cur_w] <= r_ff.sleep_ticks;
                     tstate_ff[cur_w] <= rtos_pkg::ST_DELAYED;
                     rsp_ff.done_ok <= 1'b1; rsp_ff.switch_request <= 1'b1;
                  end
               end
               rtos_pkg::REQ_WAIT: begin
                  if (tstate_ff[cur_w] == rtos_pkg::ST_INVALID) begin
                  end else if (!sem_ok) rsp_ff.error_code <= rtos_pkg::ERR_BAD_SEM;
                  else if (count_ff[sem_w] != 0) begin
                     count_ff[sem_w] <= count_ff[sem_w] - 1'b1;
                     hvalid_ff[cur_w] <= 1'b1; hsem_ff[cur_w] <= sem_w;
                     rsp_ff.done_ok <= 1'b1;
                  end else if (32'(qlen_ff[sem_w]) >= QUEUE_DEPTH)
                     rsp_ff.error_code <= rtos_pkg::ERR_Q_FULL;
                  else begin
                     qlen_ff[sem_w] <= qlen_ff[sem_w] + 1'b1;
                     tstate_ff[cur_w] <= rtos_pkg::ST_BLOCKED;
                     hvalid_ff[cur_w] <= 1'b1; hsem_ff[cur_w] <= sem_w;
                     rsp_ff.done_ok <= 1'b1; rsp_ff.switch_request <= 1'b1;
                  end
               end
               rtos_pkg::REQ_POST: begin
                  if (!sem_ok) rsp_ff.error_code <= rtos_pkg::ERR_BAD_SEM;
                  else begin
                     aprio_ff[cur_w] <= bprio_ff[cur_w];
                     if (qlen_ff[sem_w] != 0) begin
                        qlen_ff[sem_w] <= qlen_ff[sem_w] - 1'b1;
                        qhead_ff[sem_w] <= (32'(qhead_ff[sem_w]) == QUEUE_DEPTH - 1) ?
                                           '0 : qhead_ff[sem_w] + 1'b1;
                        tstate_ff[qhead_data] <= rtos_pkg::ST_READY;
                        rsp_ff.released <= 1'b1;
                        rsp_ff.task_index <= 4'(qhead_data);
                     end else if (count_ff[sem_w] != rtos_pkg::COUNT_MAX)
                        count_ff[sem_w] <= count_ff[sem_w] + 1'b1;
                     rsp_ff.done_ok <= 1'b1;
                  end
               end
               default: begin
                  if (32'(sems_ff) >= NUM_SEMS) rsp_ff.error_code <= rtos_pkg::ERR_FULL;
                  else begin
                     count_ff[SW'(sems_ff)] <= r_ff.initial_count;
                     qlen_ff[SW'(sems_ff)] <= '0;
                     qhead_ff[SW'(sems_ff)] <= '0;
                     sems_ff <= sems_ff + 1'b1;
                     rsp_ff.new_sem <= 3'(sems_ff);
                     rsp_ff.done_ok <= 1'b1;
                  end
               end
            endcase
         end
      end
   end
endmodule

// ----- rtl/rtos_checker.sv -----
// ----------------------------------------------------------------------------
// rtos_checker
// Port-level checks of the kernel core.
// ----------------------------------------------------------------------------
module rtos_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rtos_pkg::rsp_type      rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped while stalled");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken during work");
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken with response pending");
   a_err_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.done_ok |-> rsp_payload.error_code == rtos_pkg::ERR_NONE)
      else $error("success with error code");
endmodule

bind rtos_task_scheduler_kernel_core rtos_checker u_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);

// ----- tb/rtos_task_scheduler_kernel_core_test.sv -----
// ----------------------------------------------------------------------------
// rtos_task_scheduler_kernel_core_test
// Drives kernel requests with random gaps and stalls, predicts every response
// from a behavioral copy of the task table and semaphores, and compares.
// ----------------------------------------------------------------------------
module rtos_task_scheduler_kernel_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NT = 16;
   localparam int NS = 8;
   localparam int QD = 8;
   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = rtos_pkg::CSR_PRIORITY;
   logic csr_write_data = 1'b0;

   rtos_stream_if #(.PAYLOAD_TYPE(rtos_pkg::req_type_type)) req_ch ();
   rtos_stream_if #(.PAYLOAD_TYPE(rtos_pkg::rsp_type)) rsp_ch ();

   rtos_task_scheduler_kernel_core i_dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // kernel shadow
   logic       prio_mode, preempt_on, inherit_on;
   logic [2:0] slot_state [NT];
   logic [31:0] slot_key [NT];
   logic [3:0] slot_base [NT];
   logic [3:0] slot_active [NT];
   logic [3:0] slot_skip [NT];
   logic [31:0] slot_ticks [NT];
   logic       slot_holds [NT];
   logic [2:0] slot_held_sem [NT];
   logic [3:0] pick_ptr, cur_task;
   int         live_tasks, live_sems;
   logic [15:0] sem_count [NS];
   logic [3:0] waiters [NS][QD];
   int         waiter_len [NS];

   rtos_pkg::rsp_type expected_rsp [$];
   int         mismatches = 0;
   longint     cycle_count = 0;
   bit         stall_rsp = 1'b0;
   int         rsp_hold = 0;

   function automatic bit can_run(int t);
      return slot_state[t] == rtos_pkg::ST_READY || slot_state[t] == rtos_pkg::ST_UNRUN;
   endfunction

   task automatic kernel_reset();
      prio_mode = 1'b1; preempt_on = 1'b1; inherit_on = 1'b0;
      for (int i = 0; i < NT; i++) begin
         slot_state[i] = rtos_pkg::ST_INVALID; slot_key[i] = '0; slot_base[i] = '0;
         slot_active[i] = '0; slot_skip[i] = '0; slot_ticks[i] = '0;
         slot_holds[i] = 1'b0; slot_held_sem[i] = '0;
      end
      pick_ptr = 4'(NT - 1); cur_task = '0; live_tasks = 0; live_sems = 0;
      for (int s = 0; s < NS; s++) begin
         sem_count[s] = '0; waiter_len[s] = 0;
      end
   endtask

   function automatic rtos_pkg::rsp_type kernel_predict(rtos_pkg::req_type_type r);
      rtos_pkg::rsp_type o;
      logic [3:0] p, cur, t;
      int i, s;
      bit any;
      o = '0;
      p = r.task_priority ^ 4'h8;
      cur = cur_task;
      s = int'(r.sem_index);
      case (r.req_type)
         rtos_pkg::REQ_CREATE: begin
            if (live_tasks >= NT) o.error_code = rtos_pkg::ERR_FULL;
            else begin
               any = 0;
               for (i = 0; i < NT; i++)
                  if (slot_state[i] != rtos_pkg::ST_INVALID && slot_key[i] == r.task_key)
                     any = 1;
               if (any) o.error_code = rtos_pkg::ERR_DUP;
               else begin
                  for (i = 0; i < NT && slot_state[i] != rtos_pkg::ST_INVALID; i++) ;
                  slot_state[i] = rtos_pkg::ST_UNRUN; slot_key[i] = r.task_key;
                  slot_base[i] = p; slot_active[i] = p; slot_skip[i] = '0;
                  slot_ticks[i] = '0; slot_holds[i] = 1'b0; slot_held_sem[i] = '0;
                  live_tasks++;
                  o.done_ok = 1'b1; o.task_index = 4'(i);
               end
            end
         end
         rtos_pkg::REQ_TICK: begin
            o.switch_request = preempt_on;
            for (i = 0; i < NT; i++)
               if (slot_state[i] == rtos_pkg::ST_DELAYED) begin
                  if (slot_ticks[i] > 0) slot_ticks[i]--;
                  else slot_state[i] = rtos_pkg::ST_READY;
               end
            o.done_ok = 1'b1;
         end
         rtos_pkg::REQ_DISPATCH: begin
            any = 0;
            for (i = 0; i < NT; i++) if (can_run(i)) any = 1;
            if (!any) o.error_code = rtos_pkg::ERR_NO_READY;
            else begin
               t = pick_ptr;
               for (i = 0; i < 17 * NT; i++) begin
                  t = t + 1'b1;
                  if (prio_mode) begin
                     if (can_run(t)) begin
                        if (slot_skip[t] < slot_active[t]) slot_skip[t]++;
                        else begin
                           slot_skip[t] = '0;
                           break;
                        end
                     end
                  end else begin
                     slot_skip[t] = '0;
                     if (can_run(t)) break;
                  end
               end
               pick_ptr = t; cur_task = t;
               o.first_run = slot_state[t] == rtos_pkg::ST_UNRUN;
               slot_state[t] = rtos_pkg::ST_READY;
               o.done_ok = 1'b1; o.task_index = t;
            end
         end
         rtos_pkg::REQ_YIELD: if (slot_state[cur] != rtos_pkg::ST_INVALID) begin
            slot_state[cur] = rtos_pkg::ST_READY;
            o.done_ok = 1'b1; o.switch_request = 1'b1;
         end
         rtos_pkg::REQ_SLEEP: if (slot_state[cur] != rtos_pkg::ST_INVALID) begin
            slot_ticks[cur] = r.sleep_ticks; slot_state[cur] = rtos_pkg::ST_DELAYED;
            o.done_ok = 1'b1; o.switch_request = 1'b1;
         end
         rtos_pkg::REQ_WAIT: if (slot_state[cur] != rtos_pkg::ST_INVALID) begin
            if (s >= live_sems) o.error_code = rtos_pkg::ERR_BAD_SEM;
            else if (sem_count[s] > 0) begin
               sem_count[s]--; slot_holds[cur] = 1'b1; slot_held_sem[cur] = 3'(s);
               o.done_ok = 1'b1;
            end else if (waiter_len[s] >= QD) o.error_code = rtos_pkg::ERR_Q_FULL;
            else begin
               waiters[s][waiter_len[s]] = cur; waiter_len[s]++;
               slot_state[cur] = rtos_pkg::ST_BLOCKED; slot_holds[cur] = 1'b1;
               slot_held_sem[cur] = 3'(s);
               if (inherit_on)
                  for (i = 0; i < NT; i++)
                     if (slot_holds[i] && slot_held_sem[i] == 3'(s) &&
                         slot_active[i] > slot_active[cur])
                        slot_active[i] = slot_active[cur];
               o.done_ok = 1'b1; o.switch_request = 1'b1;
            end
         end
         rtos_pkg::REQ_POST: begin
            if (s >= live_sems) o.error_code = rtos_pkg::ERR_BAD_SEM;
            else begin
               slot_active[cur] = slot_base[cur];
               if (waiter_len[s] > 0) begin
                  t = waiters[s][0];
                  for (i = 0; i + 1 < waiter_len[s]; i++) waiters[s][i] = waiters[s][i + 1];
                  waiter_len[s]--;
                  slot_state[t] = rtos_pkg::ST_READY;
                  o.released = 1'b1; o.task_index = t;
               end else if (sem_count[s] < rtos_pkg::COUNT_MAX) sem_count[s]++;
               o.done_ok = 1'b1;
            end
         end
         default: begin
            if (live_sems >= NS) o.error_code = rtos_pkg::ERR_FULL;
            else begin
               o.new_sem = 3'(live_sems);
               sem_count[live_sems] = r.initial_count; waiter_len[live_sems] = 0;
               live_sems++;
               o.done_ok = 1'b1;
            end
         end
      endcase
      return o;
   endfunction

   // stimulus driver
   task automatic send_request(logic [2:0] kind, logic [31:0] key = $urandom,
                               logic [3:0] prio = 4'($urandom),
                               logic [31:0] ticks = $urandom_range(0, 4),
                               logic [2:0] sem = 3'($urandom),
                               logic [15:0] count = 16'($urandom_range(0, 3)));
      rtos_pkg::req_type_type r;
      int gap;
      r = '{kind, key, prio, ticks, sem, count};
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 15));
      repeat (gap) @(posedge clock);
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      req_ch.valid <= 1'b0;
      expected_rsp.push_back(kernel_predict(r));
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_mode(logic [1:0] idx, logic val);
      csr_write_enable <= 1'b1; csr_index <= idx; csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         rtos_pkg::CSR_PRIORITY: prio_mode = val;
         rtos_pkg::CSR_PREEMPT: preempt_on = val;
         default: inherit_on = val;
      endcase
      @(posedge clock);
   endtask

   // response checker; after each accepted response ready is held off by a random draw unless stall_rsp is set
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_ch.payload);
            end else begin
               rtos_pkg::rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp_ch.payload !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", e, rsp_ch.payload);
               end
            end
            rsp_hold = stall_rsp ? 0 : int'($urandom_range(0, 15));
         end else if (rsp_ch.valid && rsp_hold > 0) rsp_hold--;
         rsp_ch.ready <= (rsp_hold == 0);
      end
   end

   task automatic test_directed();
      send_request(rtos_pkg::REQ_DISPATCH);                 // nothing ready
      send_request(rtos_pkg::REQ_YIELD);                    // running slot invalid
      send_request(rtos_pkg::REQ_WAIT, , , , 3'd0);
      send_request(rtos_pkg::REQ_POST, , , , 3'd0);         // unknown semaphore
      send_request(rtos_pkg::REQ_CREATE, 32'h0, 4'h8);      // highest priority
      send_request(rtos_pkg::REQ_CREATE, 32'hFFFF_FFFF, 4'h7);
      send_request(rtos_pkg::REQ_CREATE, 32'h0, 4'h0);      // duplicate key
      send_request(rtos_pkg::REQ_SEM, , , , , 16'hFFFF);
      send_request(rtos_pkg::REQ_SEM, , , , , 16'h0);
      send_request(rtos_pkg::REQ_POST, , , , 3'd0);         // saturating count
      send_request(rtos_pkg::REQ_DISPATCH);
      send_request(rtos_pkg::REQ_DISPATCH);
      send_request(rtos_pkg::REQ_WAIT, , , , 3'd1);         // blocks
      send_request(rtos_pkg::REQ_WAIT, , , , 3'd7);
      send_request(rtos_pkg::REQ_POST, , , , 3'd1);         // releases waiter
      send_request(rtos_pkg::REQ_SLEEP, , , 32'h0);
      send_request(rtos_pkg::REQ_TICK);
      send_request(rtos_pkg::REQ_SLEEP, , , 32'hFFFF_FFFF);
      send_request(rtos_pkg::REQ_TICK);
      send_request(rtos_pkg::REQ_DISPATCH);
      drain();
   endtask

   task automatic test_fill_tables();
      for (int i = 0; i < 16; i++) send_request(rtos_pkg::REQ_CREATE, $urandom, 4'($urandom));
      send_request(rtos_pkg::REQ_CREATE);                   // task table full
      for (int i = 0; i < 8; i++) send_request(rtos_pkg::REQ_SEM, , , , , 16'($urandom));
      drain();
   endtask

   task automatic test_random(int n);
      for (int k = 0; k < n; k++) begin
         int pick;
         pick = int'($urandom_range(0, 99));
         if (pick < 22) send_request(rtos_pkg::REQ_DISPATCH);
         else if (pick < 32) send_request(rtos_pkg::REQ_TICK);
         else if (pick < 42) send_request(rtos_pkg::REQ_YIELD);
         else if (pick < 50) send_request(rtos_pkg::REQ_SLEEP, , , $urandom_range(0, 1) ?
                                          $urandom_range(0, 3) : $urandom);
         else if (pick < 68) send_request(rtos_pkg::REQ_WAIT, , , , 3'($urandom_range(0, 7)));
         else if (pick < 86) send_request(rtos_pkg::REQ_POST, , , , 3'($urandom_range(0, 7)));
         else if (pick < 94) send_request(rtos_pkg::REQ_CREATE, $urandom_range(0, 40));
         else send_request(rtos_pkg::REQ_SEM);
      end
      drain();
   endtask

   task automatic test_modes();
      logic [2:0] combo;
      for (int ph = 0; ph < 8; ph++) begin
         combo = 3'(ph);
         write_mode(rtos_pkg::CSR_PRIORITY, combo[0]);
         write_mode(rtos_pkg::CSR_PREEMPT, combo[1]);
         write_mode(rtos_pkg::CSR_INHERIT, combo[2]);
         test_random(200);
         stall_rsp = (ph == 3);
      end
      stall_rsp = 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      kernel_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_tables();
      test_random(150);
      test_modes();
      kernel_reset();
      if (mismatches == 0 && expected_rsp.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/rtos_pkg.sv
rtl/rtos_stream_if.sv
rtl/rtos_ctrl.sv
rtl/rtos_datapath.sv
rtl/rtos_task_scheduler_kernel_core.sv
rtl/rtos_checker.sv
tb/rtos_task_scheduler_kernel_core_test.sv
